// ===== src/rvma_pkg.sv =====
// shared types and constants of the variable window moving average
package rvma_pkg;

	localparam int WIN_REG_W = 8;
	localparam logic [WIN_REG_W-1:0] WINDOW_RESET = 8'd10;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic {
		FR_IDLE,
		FR_UPDATE
	} front_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage

// ===== src/rvma_ifs.sv =====
// channel interfaces of the variable window moving average
interface rvma_sample_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface rvma_average_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH-1:0] average;

	modport source (output valid, output average, input ready);
	modport sink (input valid, input average, output ready);
endinterface

interface rvma_cfg_if import rvma_pkg::*; ();
	logic valid;
	logic ready;
	logic [WIN_REG_W-1:0] window_length;

	modport source (output valid, output window_length, input ready);
	modport sink (input valid, input window_length, output ready);
endinterface

// ===== src/rvma_front.sv =====
// front end: window register, sample ring and running sum update
module rvma_front import rvma_pkg::*; #(
	parameter int MAX_WINDOW = 128,
	parameter int SAMPLE_WIDTH = 16,
	localparam int PTR_W = $clog2(MAX_WINDOW),
	localparam int CNT_W = $clog2(MAX_WINDOW + 1),
	localparam int SUM_W = SAMPLE_WIDTH + PTR_W + 1
) (
	input  logic clk,
	input  logic arst_n,
	rvma_sample_if.sink sample_req,
	rvma_cfg_if.sink window_cfg,
	output logic push_valid,
	input  logic push_ready,
	output logic [SUM_W+CNT_W-1:0] push_data
);

	front_state_t state_q, state_d;
	logic [WIN_REG_W-1:0] win_len_q;
	logic [CNT_W-1:0] in_use_q, cnt_q, cnt_next, eff_win;
	logic [PTR_W-1:0] pos_q, pos_base, pos_use, pos_next;
	logic [CNT_W-1:0] pos_inc;
	logic signed [SUM_W-1:0] sum_q, sum_new, add_val, sub_val;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1, rd_s1;
	logic signed [SAMPLE_WIDTH-1:0] ring_q [MAX_WINDOW];
	logic acc, clr, full, push_fire;

	assign window_cfg.ready = 1'b1;
	assign sample_req.ready = (state_q == FR_IDLE);
	assign acc = sample_req.valid && sample_req.ready;
	assign push_fire = push_valid && push_ready;

	always_comb begin
		priority if (win_len_q == '0) begin
			eff_win = CNT_W'(1);
		end else if (int'(win_len_q) > MAX_WINDOW) begin
			eff_win = CNT_W'(MAX_WINDOW);
		end else begin
			eff_win = CNT_W'(win_len_q);
		end
	end

	// new effective window length restarts the average
	assign clr = (eff_win != in_use_q);
	assign pos_base = clr ? '0 : pos_q;
	assign pos_use = (CNT_W'(pos_base) >= eff_win) ? '0 : pos_base;

	assign full = (cnt_q >= in_use_q);
	assign add_val = {{(SUM_W-SAMPLE_WIDTH){sample_s1[SAMPLE_WIDTH-1]}}, sample_s1};
	assign sub_val = full ? {{(SUM_W-SAMPLE_WIDTH){rd_s1[SAMPLE_WIDTH-1]}}, rd_s1} : '0;
	assign sum_new = sum_q - sub_val + add_val;
	assign pos_inc = CNT_W'(pos_q) + CNT_W'(1);
	assign pos_next = (pos_inc >= in_use_q) ? '0 : pos_inc[PTR_W-1:0];
	assign cnt_next = full ? cnt_q : cnt_q + CNT_W'(1);
	assign push_data = {sum_new, cnt_next};

	always_comb begin
		state_d = state_q;
		push_valid = 1'b0;
		unique case (state_q)
			FR_IDLE: begin
				if (acc) begin
					state_d = FR_UPDATE;
				end
			end
			FR_UPDATE: begin
				push_valid = 1'b1;
				if (push_ready) begin
					state_d = FR_IDLE;
				end
			end
			default: begin
				state_d = FR_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			win_len_q <= WINDOW_RESET;
			in_use_q <= '0;
			pos_q <= '0;
			cnt_q <= '0;
			sum_q <= '0;
		end else begin
			state_q <= state_d;
			if (window_cfg.valid) begin
				win_len_q <= window_cfg.window_length;
			end
			if (acc) begin
				in_use_q <= eff_win;
				pos_q <= pos_use;
				if (clr) begin
					cnt_q <= '0;
					sum_q <= '0;
				end
			end
			if (push_fire) begin
				pos_q <= pos_next;
				cnt_q <= cnt_next;
				sum_q <= sum_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			sample_s1 <= sample_req.sample;
			rd_s1 <= ring_q[pos_use];
		end
		if (push_fire) begin
			ring_q[pos_q] <= sample_s1;
		end
	end

endmodule

// ===== src/rvma_fifo.sv =====
// short queue between front end and divider
module rvma_fifo import rvma_pkg::*; #(
	parameter int WIDTH = 32,
	localparam int PTR_W = $clog2(QUEUE_DEPTH),
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push_fire, pop_fire;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign push_fire = push_valid && push_ready;
	assign pop_fire = pop_valid && pop_ready;

	// pointers wrap naturally, depth is a power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop_fire) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== src/rvma_div.sv =====
// back end: radix-2 signed divide of the sum by the sample count
module rvma_div import rvma_pkg::*; #(
	parameter int MAX_WINDOW = 128,
	parameter int SAMPLE_WIDTH = 16,
	localparam int PTR_W = $clog2(MAX_WINDOW),
	localparam int CNT_W = $clog2(MAX_WINDOW + 1),
	localparam int SUM_W = SAMPLE_WIDTH + PTR_W + 1,
	localparam int STEP_W = $clog2(SUM_W)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pop_valid,
	output logic pop_ready,
	input  logic [SUM_W+CNT_W-1:0] pop_data,
	rvma_average_if.source average_req
);

	back_state_t state_q, state_d;
	logic [SUM_W-1:0] pop_sum, pop_mag, quo_q;
	logic [CNT_W-1:0] pop_cnt, div_q, rem_q;
	logic [CNT_W:0] trial, diff;
	logic [STEP_W-1:0] step_q;
	logic [SAMPLE_WIDTH-1:0] q_mag;
	logic signed [SAMPLE_WIDTH-1:0] avg_q, avg_d;
	logic neg_q, ge, last, load_out, avg_valid_q, pop_fire;

	assign pop_sum = pop_data[SUM_W+CNT_W-1:CNT_W];
	assign pop_cnt = pop_data[CNT_W-1:0];
	assign pop_mag = pop_sum[SUM_W-1] ? (~pop_sum + SUM_W'(1)) : pop_sum;
	assign pop_fire = pop_valid && pop_ready;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge = (trial >= {1'b0, div_q});
	assign diff = trial - {1'b0, div_q};
	assign last = (step_q == STEP_W'(SUM_W - 1));

	// quotient magnitude never exceeds the sample range plus one
	assign q_mag = quo_q[SAMPLE_WIDTH-1:0];
	assign avg_d = neg_q ? (~q_mag + SAMPLE_WIDTH'(1)) : q_mag;

	assign average_req.valid = avg_valid_q;
	assign average_req.average = avg_q;

	always_comb begin
		state_d = state_q;
		pop_ready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (last) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (!avg_valid_q || average_req.ready) begin
					load_out = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			avg_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				avg_valid_q <= 1'b1;
			end else if (average_req.ready) begin
				avg_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_fire) begin
			neg_q <= pop_sum[SUM_W-1];
			quo_q <= pop_mag;
			div_q <= pop_cnt;
			rem_q <= '0;
			step_q <= '0;
		end else if (state_q == BK_DIV) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
			step_q <= step_q + STEP_W'(1);
		end
		if (load_out) begin
			avg_q <= avg_d;
		end
	end

endmodule

// ===== src/variable_window_moving_average.sv =====
// top level of the variable window moving average
//
//   channel       role   payload                       notes
//   sample_req    sink   sample, SAMPLE_WIDTH signed   one request per sample
//   average_req   source average, SAMPLE_WIDTH signed  one result per sample
//   window_cfg    sink   window_length, 8 bits         always ready
//
// front end takes a new sample only once the last one is pushed into the queue;
// the radix-2 divider pops the next entry only after its result is registered
// asynchronous reset clears control, sum, position and count; ring is not cleared
// a finished average waits in the output register while the divider and a
// two-entry queue keep taking samples
module variable_window_moving_average import rvma_pkg::*; #(
	parameter int MAX_WINDOW = 128,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	rvma_sample_if.sink sample_req,
	rvma_average_if.source average_req,
	rvma_cfg_if.sink window_cfg
);

	localparam int PTR_W = $clog2(MAX_WINDOW);
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = SAMPLE_WIDTH + PTR_W + 1;
	localparam int ENTRY_W = SUM_W + CNT_W;

	logic push_valid, push_ready, pop_valid, pop_ready;
	logic [ENTRY_W-1:0] push_data, pop_data;

	rvma_front #(
		.MAX_WINDOW(MAX_WINDOW),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.sample_req(sample_req),
		.window_cfg(window_cfg),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	rvma_fifo #(
		.WIDTH(ENTRY_W)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	rvma_div #(
		.MAX_WINDOW(MAX_WINDOW),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.average_req(average_req)
	);

endmodule

// ===== src/rvma_checker.sv =====
// port level checks of the variable window moving average
module rvma_checker #(
	parameter int SAMPLE_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	input logic sample_ready,
	input logic average_valid,
	input logic average_ready,
	input logic [SAMPLE_WIDTH-1:0] average
);

	logic [2:0] pending_q;
	logic in_fire, out_fire;

	assign in_fire = sample_valid && sample_ready;
	assign out_fire = average_valid && average_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_fire && !out_fire) begin
			pending_q <= pending_q + 3'd1;
		end else if (out_fire && !in_fire) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> (pending_q != 3'd0 || in_fire))
		else $error("result without a pending request");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd5)
		else $error("more requests in flight than the design can hold");

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		average_valid && !average_ready |=> average_valid)
		else $error("average dropped while stalled");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		average_valid && !average_ready |=> $stable(average))
		else $error("average changed while stalled");

endmodule

bind variable_window_moving_average rvma_checker #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_rvma_checker (
	.clk(clk),
	.arst_n(arst_n),
	.sample_valid(sample_req.valid),
	.sample_ready(sample_req.ready),
	.average_valid(average_req.valid),
	.average_ready(average_req.ready),
	.average(average_req.average)
);

// ===== tb/tb_variable_window_moving_average.sv =====
// testbench of the variable window moving average: directed table, random windows, stalls
`timescale 1ns / 100ps

module tb_variable_window_moving_average import rvma_pkg::*;;

	localparam int MAX_WIN = 128;
	localparam int SLOT_W = $clog2(MAX_WIN);
	localparam int SMP_W = 16;
	localparam logic signed [SMP_W-1:0] S_MAX = 16'sh7FFF;
	localparam logic signed [SMP_W-1:0] S_MIN = 16'sh8000;
	localparam int IDLE_MAX = 17;
	localparam int RANDOM_ITEMS = 750;
	localparam int HOLD_CYCLES = 400;
	localparam int N_ROWS = 27;

	typedef enum bit {
		ROW_SAMPLE,
		ROW_WINDOW
	} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic [WIN_REG_W-1:0] window;
		logic signed [SMP_W-1:0] smp;
		bit typed;
		logic signed [SMP_W-1:0] avg;
	} stim_row_t;

	logic clk;
	logic arst_n;

	rvma_sample_if #(.SAMPLE_WIDTH(SMP_W)) sample_ch ();
	rvma_average_if #(.SAMPLE_WIDTH(SMP_W)) avg_ch ();
	rvma_cfg_if cfg_ch ();

	variable_window_moving_average #(
		.MAX_WINDOW(MAX_WIN),
		.SAMPLE_WIDTH(SMP_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_req(sample_ch),
		.average_req(avg_ch),
		.window_cfg(cfg_ch)
	);

	// averager model state
	logic signed [SMP_W-1:0] held_samples [MAX_WIN];
	longint window_sum;
	int unsigned write_slot;
	int unsigned fill_count;
	int unsigned active_window;
	logic [WIN_REG_W-1:0] window_setting;

	logic signed [SMP_W-1:0] expected_averages [$];
	int mismatch_count;
	int tx_idle_max;
	int rx_idle_max;

	stim_row_t stim_rows [N_ROWS] = '{
		'{ROW_SAMPLE, 8'd0, S_MAX, 1'b1, S_MAX},
		'{ROW_SAMPLE, 8'd0, S_MIN, 1'b0, 16'sd0},
		'{ROW_SAMPLE, 8'd0, S_MIN, 1'b0, 16'sd0},
		'{ROW_WINDOW, 8'd1, 16'sd0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, 8'd0, S_MIN, 1'b1, S_MIN},
		'{ROW_SAMPLE, 8'd0, S_MAX, 1'b1, S_MAX},
		'{ROW_WINDOW, 8'd0, 16'sd0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, 8'd0, 16'sd5, 1'b1, 16'sd5},
		'{ROW_SAMPLE, 8'd0, -16'sd1, 1'b1, -16'sd1},
		'{ROW_WINDOW, 8'd255, 16'sd0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, 8'd0, S_MIN, 1'b1, S_MIN},
		'{ROW_SAMPLE, 8'd0, S_MIN, 1'b1, S_MIN},
		'{ROW_WINDOW, 8'd128, 16'sd0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, 8'd0, S_MIN, 1'b1, S_MIN},
		'{ROW_SAMPLE, 8'd0, 16'sd12345, 1'b0, 16'sd0},
		'{ROW_WINDOW, 8'd2, 16'sd0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, 8'd0, 16'sd100, 1'b1, 16'sd100},
		'{ROW_SAMPLE, 8'd0, -16'sd7, 1'b0, 16'sd0},
		'{ROW_SAMPLE, 8'd0, -16'sd100, 1'b0, 16'sd0},
		'{ROW_SAMPLE, 8'd0, S_MAX, 1'b0, 16'sd0},
		'{ROW_WINDOW, 8'd3, 16'sd0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, 8'd0, 16'sd1, 1'b1, 16'sd1},
		'{ROW_SAMPLE, 8'd0, -16'sd2, 1'b0, 16'sd0},
		'{ROW_SAMPLE, 8'd0, -16'sd2, 1'b0, 16'sd0},
		'{ROW_SAMPLE, 8'd0, -16'sd2, 1'b0, 16'sd0},
		'{ROW_WINDOW, WINDOW_RESET, 16'sd0, 1'b0, 16'sd0},
		'{ROW_SAMPLE, 8'd0, 16'sd7, 1'b1, 16'sd7}
	};

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic signed [SMP_W-1:0] predict_average(input logic signed [SMP_W-1:0] smp);
		int unsigned eff;
		longint quot;
		if (window_setting == 0)
			eff = 1;
		else if (window_setting > MAX_WIN)
			eff = MAX_WIN;
		else
			eff = int'(window_setting);
		if (eff != active_window) begin
			active_window = eff;
			window_sum = 0;
			write_slot = 0;
			fill_count = 0;
		end
		if (write_slot >= eff)
			write_slot = 0;
		if (fill_count >= eff)
			window_sum -= longint'(held_samples[SLOT_W'(write_slot)]);
		held_samples[SLOT_W'(write_slot)] = smp;
		window_sum += longint'(smp);
		write_slot = (write_slot + 1 >= eff) ? 0 : write_slot + 1;
		if (fill_count < eff)
			fill_count++;
		quot = window_sum / longint'(fill_count);
		return quot[SMP_W-1:0];
	endfunction

	task automatic flag_mismatch(input string what, input logic signed [SMP_W-1:0] want,
			input logic signed [SMP_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s average expected %0d got %0d", $time, what, want, got);
	endtask

	// caller stands at a falling edge
	task automatic send_sample(input logic signed [SMP_W-1:0] smp, input bit typed,
			input logic signed [SMP_W-1:0] typed_avg);
		int gap;
		logic signed [SMP_W-1:0] want;
		gap = $urandom_range(0, tx_idle_max);
		if (gap > 0) begin
			sample_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid = 1'b1;
		sample_ch.sample = smp;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		want = predict_average(smp);
		expected_averages.push_back(typed ? typed_avg : want);
		@(negedge clk);
	endtask

	task automatic write_window(input logic [WIN_REG_W-1:0] value);
		sample_ch.valid = 1'b0;
		wait (expected_averages.size() == 0);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.window_length = value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		window_setting = value;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// result checker
	initial begin
		int wait_left;
		int hold_left;
		int results;
		logic signed [SMP_W-1:0] want;
		wait_left = 0;
		hold_left = 0;
		results = 0;
		rx_idle_max = IDLE_MAX;
		avg_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				avg_ch.ready = 1'b0;
				hold_left--;
			end else if (wait_left > 0) begin
				avg_ch.ready = 1'b0;
				wait_left--;
			end else begin
				avg_ch.ready = 1'b1;
			end
			@(posedge clk);
			if (avg_ch.valid && avg_ch.ready) begin
				results++;
				if (expected_averages.size() == 0) begin
					flag_mismatch("unexpected", 'x, avg_ch.average);
				end else begin
					want = expected_averages.pop_front();
					if (avg_ch.average !== want)
						flag_mismatch("wrong", want, avg_ch.average);
				end
				if (results % 50 == 0)
					rx_idle_max = $urandom_range(0, 1) ? IDLE_MAX : 0;
				wait_left = $urandom_range(0, rx_idle_max);
				if (results == 150 || results == 480)
					hold_left = HOLD_CYCLES;
			end
		end
	end

	initial begin
		int random_items;
		int eff;
		int count;
		int mode;
		int pick;
		logic [WIN_REG_W-1:0] win;
		logic signed [SMP_W-1:0] smp;

		mismatch_count = 0;
		window_sum = 0;
		write_slot = 0;
		fill_count = 0;
		active_window = 0;
		window_setting = WINDOW_RESET;
		foreach (held_samples[i])
			held_samples[i] = '0;
		tx_idle_max = IDLE_MAX;
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.window_length = WINDOW_RESET;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_WINDOW)
				write_window(stim_rows[i].window);
			else
				send_sample(stim_rows[i].smp, stim_rows[i].typed, stim_rows[i].avg);
		end

		random_items = 0;
		win = WINDOW_RESET;
		while (random_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 11);
			case (pick)
				0: win = 8'd0;
				1: win = 8'd1;
				2: win = 8'd2;
				3: win = 8'd128;
				4: win = 8'd255;
				5: win = 8'($urandom_range(129, 254));
				6: win = 8'($urandom_range(41, 127));
				7: ; // same setting again
				default: win = 8'($urandom_range(1, 40));
			endcase
			write_window(win);
			eff = (win == 0) ? 1 : (win > MAX_WIN) ? MAX_WIN : int'(win);
			count = (eff <= 20) ? $urandom_range(8, 50) : eff + $urandom_range(5, 40);
			mode = $urandom_range(0, 5);
			tx_idle_max = $urandom_range(0, 2) ? IDLE_MAX : 0;
			repeat (count) begin
				case (mode)
					0: smp = S_MAX;
					1: smp = S_MIN;
					2: smp = 16'(int'($urandom_range(0, 200)) - 100);
					default: begin
						pick = $urandom_range(0, 7);
						smp = (pick == 0) ? S_MAX : (pick == 1) ? S_MIN : 16'($urandom());
					end
				endcase
				send_sample(smp, 1'b0, '0);
				random_items++;
			end
		end
		sample_ch.valid = 1'b0;

		wait (expected_averages.size() == 0);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && expected_averages.size() == 0)
			$display("tb_variable_window_moving_average: PASS");
		else
			$display("tb_variable_window_moving_average: FAIL");
		$finish;
	end

	initial begin
		#4000000;
		$display("tb_variable_window_moving_average: FAIL");
		$finish;
	end

endmodule
